>>> src/ubd_pkg.sv
`timescale 1ns / 1ps

package ubd_pkg;

   localparam logic [27:0] INTERNAL_HZ = 28'd16000000;
   localparam logic [27:0] EXTERNAL_HZ = 28'd8000000;
   localparam logic [27:0] PLL_IN_HZ   = 28'd8000000;

   localparam logic [1:0] SRC_INTERNAL = 2'd0;
   localparam logic [1:0] SRC_EXTERNAL = 2'd1;
   localparam logic [1:0] SRC_PLL      = 2'd2;
   localparam logic [1:0] SRC_NONE     = 2'd3;

   localparam int unsigned NUM_W  = 32;   // 25 * bus clock
   localparam int unsigned DEN_W  = 25;   // baud * 2 or baud * 4
   localparam int unsigned MANT_W = 25;

   // quotient / 100 == (q * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit q
   localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
   localparam int unsigned DIV100_SHIFT = 37;
   // x / 100 == (x * FRAC_MAGIC) >> FRAC_SHIFT for x below 2048
   localparam logic [13:0] FRAC_MAGIC = 14'd10486;
   localparam int unsigned FRAC_SHIFT = 20;

   typedef struct packed {
      logic [22:0] baud_rate;
      logic        use_apb2;
      logic        oversample_by_8;
   } req_type;

   typedef struct packed {
      logic [27:0] brr_word;
      logic [27:0] bus_clock_hz;
      logic        divide_error;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [27:0] bus_clock_hz;
      logic [22:0] baud_rate;
      logic        oversample_by_8;
   } job_type;

   // prescaler codes map to right shifts
   function automatic logic [3:0] ahb_shift(input logic [3:0] code);
      logic [3:0] sh;
      if (!code[3]) begin
         sh = 4'd0;
      end else begin
         unique case (code[2:0])
            3'd0: sh = 4'd1;
            3'd1: sh = 4'd2;
            3'd2: sh = 4'd3;
            3'd3: sh = 4'd4;
            3'd4: sh = 4'd6;
            3'd5: sh = 4'd7;
            3'd6: sh = 4'd8;
            default: sh = 4'd9;
         endcase
      end
      return sh;
   endfunction

   function automatic logic [2:0] apb_shift(input logic [2:0] code);
      logic [2:0] sh;
      if (!code[2]) begin
         sh = 3'd0;
      end else begin
         sh = {1'b0, code[1:0]} + 3'd1;
      end
      return sh;
   endfunction

endpackage

>>> src/ubd_front.sv
`timescale 1ns / 1ps

module ubd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [31:0]       csr_wdata,
   input  ubd_pkg::req_type  req,
   output ubd_pkg::job_type  job
);

   logic [31:0] clock_config_ff;
   logic [31:0] clock_config_in;
   logic [27:0] sys_clk;
   logic [4:0]  pll_mul;
   logic [2:0]  apb_code;
   logic [3:0]  total_shift;

   assign clock_config_in = csr_write ? csr_wdata : clock_config_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_config_ff <= 32'd0;
      end else begin
         clock_config_ff <= clock_config_in;
      end
   end

   // both PLL inputs run at the same frequency
   assign pll_mul = {1'b0, clock_config_ff[21:18]} + 5'd2;

   always_comb begin
      unique case (clock_config_ff[3:2])
         ubd_pkg::SRC_INTERNAL: sys_clk = ubd_pkg::INTERNAL_HZ;
         ubd_pkg::SRC_EXTERNAL: sys_clk = ubd_pkg::EXTERNAL_HZ;
         ubd_pkg::SRC_PLL:      sys_clk = 28'(ubd_pkg::PLL_IN_HZ * 28'(pll_mul));
         ubd_pkg::SRC_NONE:     sys_clk = 28'd0;
         default:               sys_clk = 28'd0;
      endcase
   end

   assign apb_code    = req.use_apb2 ? clock_config_ff[13:11] : clock_config_ff[10:8];
   assign total_shift = ubd_pkg::ahb_shift(clock_config_ff[7:4])
                        + {1'b0, ubd_pkg::apb_shift(apb_code)};

   assign job.bus_clock_hz    = sys_clk >> total_shift;
   assign job.baud_rate       = req.baud_rate;
   assign job.oversample_by_8 = req.oversample_by_8;

endmodule

>>> src/ubd_queue.sv
`timescale 1ns / 1ps

module ubd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ubd_pkg::job_type  push_data,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output ubd_pkg::job_type  pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ubd_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/ubd_back.sv
`timescale 1ns / 1ps

module ubd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  ubd_pkg::job_type  job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ubd_pkg::rsp_type  rsp_data
);

   localparam int unsigned NW = ubd_pkg::NUM_W;
   localparam int unsigned DW = ubd_pkg::DEN_W;
   localparam int unsigned MW = ubd_pkg::MANT_W;

   typedef struct packed {
      logic [27:0] bus_clock_hz;
      logic        over8;
      logic        err;
   } meta_type;

   logic           advance;

   // stage 0 holds numerator/denominator, stages 1..NW retire one quotient bit each
   logic           vld_ff  [NW+1];
   logic [NW-1:0]  num_ff  [NW+1];
   logic [NW-1:0]  quo_ff  [NW+1];
   logic [DW-1:0]  den_ff  [NW+1];
   logic [DW-1:0]  rem_ff  [NW+1];
   meta_type       meta_ff [NW+1];

   logic           mvld_ff;
   logic [NW-1:0]  mquo_ff;
   logic [MW-1:0]  mant_ff;
   meta_type       mmeta_ff;

   logic           rsp_valid_ff;
   ubd_pkg::rsp_type rsp_ff, rsp_in;

   logic [63:0]    mant_prod;
   logic [6:0]     mod100;
   logic [10:0]    frac_num;
   logic [24:0]    frac_prod;
   logic [3:0]     frac_raw;
   logic [3:0]     frac;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign job_pop   = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0]  <= NW'({4'd0, job.bus_clock_hz} * 32'd25);
         den_ff[0]  <= job.oversample_by_8 ? {1'b0, job.baud_rate, 1'b0}
                                           : {job.baud_rate, 2'b00};
         rem_ff[0]  <= '0;
         quo_ff[0]  <= '0;
         meta_ff[0] <= '{bus_clock_hz: job.bus_clock_hz,
                         over8: job.oversample_by_8,
                         err: (job.baud_rate == 23'd0)};
      end
   end

   for (genvar k = 1; k <= NW; k++) begin : g_div
      logic [DW:0] trial;
      logic        fits;

      assign trial = {rem_ff[k-1], num_ff[k-1][NW-1]};
      assign fits  = (trial >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[k]  <= {num_ff[k-1][NW-2:0], 1'b0};
            den_ff[k]  <= den_ff[k-1];
            rem_ff[k]  <= fits ? DW'(trial - {1'b0, den_ff[k-1]}) : trial[DW-1:0];
            quo_ff[k]  <= {quo_ff[k-1][NW-2:0], fits};
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // mantissa = quotient / 100
   assign mant_prod = 64'(quo_ff[NW]) * 64'(ubd_pkg::DIV100_MAGIC);

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= 1'b0;
      end else if (advance) begin
         mvld_ff <= vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mquo_ff  <= quo_ff[NW];
         mant_ff  <= MW'(mant_prod >> ubd_pkg::DIV100_SHIFT);
         mmeta_ff <= meta_ff[NW];
      end
   end

   // remainder is below 100, so only the low bits matter
   assign mod100   = 7'(mquo_ff[6:0] - 7'(mant_ff[6:0] * 7'd100));
   assign frac_num = mmeta_ff.over8 ? 11'({mod100, 3'b000}) + 11'd50
                                    : {mod100, 4'b0000} + 11'd50;
   assign frac_prod = 25'(frac_num * ubd_pkg::FRAC_MAGIC);
   assign frac_raw  = frac_prod[ubd_pkg::FRAC_SHIFT +: 4];
   // carry out of the fraction is dropped
   assign frac      = mmeta_ff.over8 ? {1'b0, frac_raw[2:0]} : frac_raw;

   always_comb begin
      rsp_in.bus_clock_hz = mmeta_ff.bus_clock_hz;
      rsp_in.divide_error = mmeta_ff.err;
      rsp_in.brr_word     = mmeta_ff.err ? 28'd0 : {mant_ff[23:0], frac};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> src/uart_baud_divisor_calc.sv
`timescale 1ns / 1ps
// Path from request transfer to response valid: queue, prep, 32 restoring-divider
// stages, mantissa multiply, output register.
// Throughput: one request per cycle; the bit-per-stage divider pipeline
// stalls as a whole only while the response register is held.
// Reset: synchronous; clears clock_config to 0 and empties queue and pipeline.

module uart_baud_divisor_calc #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [31:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  ubd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ubd_pkg::rsp_type  rsp_data
);

   ubd_pkg::job_type front_job;
   ubd_pkg::job_type queue_job;
   logic             queue_not_empty;
   logic             queue_pop;

   ubd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req       (req_data),
      .job       (front_job)
   );

   ubd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_job),
      .not_full  (req_ready),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_job)
   );

   ubd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job       (queue_job),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> queue_not_empty)
      else $error("queue full but reported empty");

   a_error_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_error |-> rsp_data.brr_word == 28'd0)
      else $error("divide error with nonzero divisor word");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_drains: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> queue_pop)
      else $error("back end stalled with empty output register");

endmodule

>>> tb/uart_baud_divisor_calc_test.sv
`timescale 1ns / 1ps

module uart_baud_divisor_calc_test;

   localparam int unsigned LATENCY = 35;
   localparam int unsigned CYCLE_LIMIT = 400000;

   class divisor_scoreboard;
      logic [31:0]      clock_word;
      ubd_pkg::rsp_type pending[$];
      int unsigned      errors;

      function new();
         clock_word = '0;
         errors = 0;
      endfunction

      function logic [27:0] bus_clock(logic [31:0] cw, logic apb2);
         logic [31:0] sysclk;
         logic [31:0] ahb;
         logic [31:0] apb;
         logic [3:0]  code;
         logic [2:0]  pcode;
         sysclk = 0;
         ahb = 1;
         apb = 1;
         case (cw[3:2])
            ubd_pkg::SRC_INTERNAL: sysclk = 32'd16000000;
            ubd_pkg::SRC_EXTERNAL: sysclk = 32'd8000000;
            ubd_pkg::SRC_PLL:      sysclk = 32'd8000000 * (cw[21:18] + 32'd2);
            default:               sysclk = 0;
         endcase
         code = cw[7:4];
         if (code[3]) begin
            case (code[2:0])
               3'd0: ahb = 2;
               3'd1: ahb = 4;
               3'd2: ahb = 8;
               3'd3: ahb = 16;
               3'd4: ahb = 64;
               3'd5: ahb = 128;
               3'd6: ahb = 256;
               default: ahb = 512;
            endcase
         end
         pcode = apb2 ? cw[13:11] : cw[10:8];
         if (pcode[2]) apb = 32'd2 << pcode[1:0];
         return 28'((sysclk / ahb) / apb);
      endfunction

      function void note_request(ubd_pkg::req_type r);
         ubd_pkg::rsp_type e;
         logic [63:0]      clk, dv, mant, rem, frac, brr;
         clk = 64'(bus_clock(clock_word, r.use_apb2));
         e.bus_clock_hz = clk[27:0];
         e.divide_error = (r.baud_rate == 0);
         brr = 0;
         if (r.baud_rate != 0) begin
            dv = (64'd25 * clk) / ((r.oversample_by_8 ? 64'd2 : 64'd4) * 64'(r.baud_rate));
            mant = dv / 100;
            rem = dv - mant * 100;
            if (r.oversample_by_8) frac = ((rem * 8 + 50) / 100) & 64'h7;
            else frac = ((rem * 16 + 50) / 100) & 64'hF;
            brr = (mant << 4) | frac;
         end
         e.brr_word = brr[27:0];
         pending.push_back(e);
      endfunction

      function void check_response(ubd_pkg::rsp_type a);
         ubd_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("response with nothing pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.brr_word !== e.brr_word) begin
            $error("brr_word exp %0d got %0d", e.brr_word, a.brr_word);
            errors++;
         end
         if (a.bus_clock_hz !== e.bus_clock_hz) begin
            $error("bus_clock_hz exp %0d got %0d", e.bus_clock_hz, a.bus_clock_hz);
            errors++;
         end
         if (a.divide_error !== e.divide_error) begin
            $error("divide_error exp %0d got %0d", e.divide_error, a.divide_error);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_write;
   logic [31:0]      csr_wdata;
   logic             req_valid;
   logic             req_ready;
   ubd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   ubd_pkg::rsp_type rsp_data;

   divisor_scoreboard sb;
   int unsigned cycles;
   bit          calm;   // no idling on either side

   uart_baud_divisor_calc dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("uart_baud_divisor_calc test failed");
            $finish;
         end
      end
   end

   // result side: random stalls, check on each transfer
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
         rsp_ready <= calm || ($urandom_range(99) >= 34);
      end
   end

   task automatic write_clock_word(logic [31:0] w);
      csr_write <= 1;
      csr_wdata <= w;
      @(posedge clock);
      csr_write <= 0;
      sb.clock_word = w;
   endtask

   // valid stays high across back-to-back transfers; it drops only when idling
   task automatic send_request(logic [22:0] baud, logic apb2, logic over8);
      ubd_pkg::req_type r;
      r.baud_rate = baud;
      r.use_apb2 = apb2;
      r.oversample_by_8 = over8;
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [22:0] rand_baud();
      case ($urandom_range(9))
         0: return 23'($urandom_range(1, 20));
         1: return 23'($urandom);
         2: return 23'($urandom_range(4500000, 8388607));
         default: return 23'($urandom_range(300, 4500000));
      endcase
   endfunction

   logic [31:0] cfgs[8];

   initial begin
      sb = new();
      reset = 1;
      csr_write = 0;
      csr_wdata = '0;
      req_valid = 0;
      req_data = '0;
      calm = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset clock word: internal source, no prescale
      send_request(23'd115200, 0, 0);
      send_request(23'd115200, 1, 1);
      send_request(23'd0, 0, 0);
      send_request(23'd1, 0, 0);
      send_request(23'd1, 1, 1);
      send_request(23'h7FFFFF, 0, 1);
      send_request(23'd4500000, 1, 0);
      send_request(23'd9600, 0, 1);
      drain();
      // PLL x17 from external, AHB /1, APB1 /2, APB2 /1
      write_clock_word(32'h003D_0408);
      send_request(23'd115200, 0, 0);
      send_request(23'd115200, 1, 1);
      send_request(23'd3, 1, 0);
      send_request(23'd0, 1, 1);
      send_request(23'd7, 0, 1);
      drain();
      // no clock source
      write_clock_word(32'h0000_000C);
      send_request(23'd9600, 0, 0);
      send_request(23'd0, 1, 1);
      drain();
      // max prescale everywhere
      write_clock_word(32'hFFFF_FFF4);
      send_request(23'd1, 0, 0);
      send_request(23'd1, 1, 1);
      send_request(23'h7FFFFF, 1, 0);
      drain();

      cfgs[0] = 32'h0000_0000;
      cfgs[1] = 32'hFFFF_FFFF;
      cfgs[2] = 32'h003C_0008;
      cfgs[3] = 32'h0000_0004;
      for (int p = 0; p < 12; p++) begin
         if (p < 4) write_clock_word(cfgs[p]);
         else write_clock_word($urandom);
         calm = (p == 5);
         for (int i = 0; i < 78; i++)
            send_request(rand_baud(), 1'($urandom), 1'($urandom));
         drain();
      end
      calm = 0;

      if (sb.errors == 0) begin
         $display("uart_baud_divisor_calc test passed");
      end else begin
         $display("uart_baud_divisor_calc test failed");
      end
      $finish;
   end

endmodule
